FILE: sv/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPW   = 16;          // operand width
	localparam int PRW   = 2 * OPW;     // product width
	localparam int NUMW  = PRW + 1;     // result numerator width
	localparam int DENW  = PRW;         // result denominator width
	localparam int CNTW  = $clog2(NUMW + 1);

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_LT  = 3'd4,
		OP_GT  = 3'd5,
		OP_EQ  = 3'd6
	} op_t;

	// one classified item between front and back
	typedef struct packed {
		logic signed [NUMW-1:0] num;
		logic signed [DENW-1:0] den;
		logic                   flag;
		logic                   reduce;
	} item_t;

endpackage

FILE: sv/rau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front
// Registers operands, forms cross products and classifies the item.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0]             opcode,
	input  logic signed [OPW-1:0]  a_num,
	input  logic signed [OPW-1:0]  a_den,
	input  logic signed [OPW-1:0]  b_num,
	input  logic signed [OPW-1:0]  b_den,
	output logic                   push,
	output item_t                  push_item,
	input  logic                   q_ready
);

	logic                  v_s1, v_s2;
	logic [2:0]            op_s1, op_s2;
	logic signed [OPW-1:0] an_s1, ad_s1, bn_s1, bd_s1;
	logic signed [PRW-1:0] p1_s2, p2_s2, pn_s2, pd_s2;
	logic                  rdy2, adv1;
	logic signed [NUMW-1:0] num;
	logic signed [DENW-1:0] den;
	logic                  flag, arith;

	assign rdy2     = !v_s2 || q_ready;
	assign adv1     = v_s1 && rdy2;
	assign in_ready = !v_s1 || rdy2;
	assign push     = v_s2 && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (rdy2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= opcode;
			an_s1 <= a_num;
			ad_s1 <= a_den;
			bn_s1 <= b_num;
			bd_s1 <= b_den;
		end
		if (adv1) begin
			op_s2 <= op_s1;
			p1_s2 <= an_s1 * bd_s1;
			p2_s2 <= ad_s1 * bn_s1;
			pn_s2 <= an_s1 * bn_s1;
			pd_s2 <= ad_s1 * bd_s1;
		end
	end

	always_comb begin
		num   = '0;
		den   = '0;
		flag  = 1'b0;
		arith = 1'b1;
		case (op_t'(op_s2))
			OP_ADD: begin
				num = NUMW'(p1_s2) + NUMW'(p2_s2);
				den = pd_s2;
			end
			OP_SUB: begin
				num = NUMW'(p1_s2) - NUMW'(p2_s2);
				den = pd_s2;
			end
			OP_MUL: begin
				num = NUMW'(pn_s2);
				den = pd_s2;
			end
			OP_DIV: begin
				num = NUMW'(p1_s2);
				den = p2_s2;
			end
			OP_LT: begin
				arith = 1'b0;
				flag  = p1_s2 < p2_s2;
			end
			OP_GT: begin
				arith = 1'b0;
				flag  = p1_s2 > p2_s2;
			end
			OP_EQ: begin
				arith = 1'b0;
				flag  = p1_s2 == p2_s2;
			end
			default: arith = 1'b0;
		endcase
	end

	assign push_item.num    = num;
	assign push_item.den    = den;
	assign push_item.flag   = flag;
	assign push_item.reduce = arith && (num > 0) && (den > 0);

endmodule

FILE: sv/rau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module rau_queue import rau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  q_ready,
	input  logic  pop,
	output logic  q_valid,
	output item_t pop_item
);

	item_t      mem [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign q_ready  = cnt_q != 2'd2;
	assign q_valid  = cnt_q != 2'd0;
	assign pop_item = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_item;
	end

endmodule

FILE: sv/rau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back
// Binary GCD and two restoring dividers, then the output register.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  item_t                   pop_item,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [NUMW-1:0]  res_num,
	output logic signed [DENW-1:0]  res_den,
	output logic                    cmp_true
);

	typedef enum logic [2:0] {S_IDLE, S_EVEN, S_GCD, S_DIV, S_DONE} state_t;

	state_t          state_q;
	logic [NUMW-1:0] u_q, v_q, d_q, qn_q, qd_q;
	logic [NUMW:0]   rn_q, rd_q;
	logic [CNTW-1:0] k_q, cnt_q;
	logic            flag_q;
	logic [NUMW:0]   tn, td;

	assign pop = (state_q == S_IDLE) && q_valid;
	assign tn  = {rn_q[NUMW-1:0], qn_q[NUMW-1]};
	assign td  = {rd_q[NUMW-1:0], qd_q[NUMW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid && out_ready && (state_q != S_DONE))
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						qn_q   <= pop_item.num;
						qd_q   <= NUMW'(pop_item.den);
						u_q    <= pop_item.num;
						v_q    <= NUMW'(pop_item.den);
						flag_q <= pop_item.flag;
						k_q    <= '0;
						state_q <= pop_item.reduce ? S_EVEN : S_DONE;
					end
				end
				S_EVEN: begin
					// strip common factors of two
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (u_q == v_q) begin
						d_q     <= u_q << k_q;
						rn_q    <= '0;
						rd_q    <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_q > v_q) begin
						u_q <= (u_q - v_q) >> 1;
					end else begin
						v_q <= (v_q - u_q) >> 1;
					end
				end
				S_DIV: begin
					// one quotient bit per cycle in each divider
					if (tn >= {1'b0, d_q}) begin
						rn_q <= tn - {1'b0, d_q};
						qn_q <= {qn_q[NUMW-2:0], 1'b1};
					end else begin
						rn_q <= tn;
						qn_q <= {qn_q[NUMW-2:0], 1'b0};
					end
					if (td >= {1'b0, d_q}) begin
						rd_q <= td - {1'b0, d_q};
						qd_q <= {qd_q[NUMW-2:0], 1'b1};
					end else begin
						rd_q <= td;
						qd_q <= {qd_q[NUMW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(NUMW - 1))
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						res_num   <= qn_q;
						res_den   <= qd_q[DENW-1:0];
						cmp_true  <= flag_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add, subtract, multiply, divide and compare with GCD reduction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode and the two fractions;
//   output channel (out_valid/out_ready) carries res_num, res_den, cmp_true.
//   One transfer in gives exactly one transfer out, in order.
//   The front stage registers operands in s1, forms the four cross products
//   into s2 and classifies the item, then drops it into a two-entry queue.
//   The back stage handles one item at a time: comparisons and unreduced
//   fractions go from idle straight to the done state, which loads the
//   output register once it is free. Reduced fractions strip k common
//   factors of two, run a binary GCD of s subtract-and-shift steps
//   (k + s up to about 2 x 33), then two restoring dividers in parallel
//   that develop the 33 quotient bits one at a time.
//   Reset clears all valid flags and the queue; nothing needs flushing.
//   When the receiver stalls, the result waits in the output register,
//   the back stage holds its next result, and the queue and front keep
//   taking transfers until they fill.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              opcode,
	input  logic signed [OPW-1:0]   a_num,
	input  logic signed [OPW-1:0]   a_den,
	input  logic signed [OPW-1:0]   b_num,
	input  logic signed [OPW-1:0]   b_den,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [NUMW-1:0]  res_num,
	output logic signed [DENW-1:0]  res_den,
	output logic                    cmp_true
);

	logic  push, pop, q_ready, q_valid;
	item_t push_item, pop_item;

	// classify and form cross products
	rau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready)
	);

	// decouple front from the iterative back
	rau_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.pop_item  (pop_item)
	);

	// reduce and present the result
	rau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_num   (res_num),
		.res_den   (res_den),
		.cmp_true  (cmp_true)
	);

endmodule
